[src/block_status_bitmap_allocator_core_macros.svh]
// Assertion helpers used by the allocator controller.
// Each macro expects clk and rst in scope.
`ifndef BLOCK_STATUS_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_STATUS_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define BSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication.
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

[src/bsa_pkg.sv]
package bsa_pkg;

  localparam int NUM_BLOCKS      = 4096;
  localparam int BLOCK_SIZE_LOG2 = 13;

  localparam int ST_W    = 2;
  localparam int LANES   = 16;
  localparam int LANE_W  = $clog2(LANES);
  localparam int WORD_W  = LANES * ST_W;
  localparam int WORDS   = NUM_BLOCKS / LANES;
  localparam int WADDR_W = $clog2(WORDS);
  localparam int IDX_W   = $clog2(NUM_BLOCKS);

  localparam int CMD_W  = 2;
  localparam int CODE_W = 2;
  localparam int OFF_W  = 25;
  localparam int CNT_W  = 13;

  localparam logic [CNT_W-1:0] RESERVED_RESET = CNT_W'(8);

  localparam logic [ST_W-1:0] ST_UNUSED   = 2'd0;
  localparam logic [ST_W-1:0] ST_RESERVED = 2'd1;
  localparam logic [ST_W-1:0] ST_IN_USE   = 2'd2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  localparam logic [CODE_W-1:0] RC_OK       = 2'd0;
  localparam logic [CODE_W-1:0] RC_NO_SPACE = 2'd1;
  localparam logic [CODE_W-1:0] RC_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_WR,
    S_INIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              in_load;
    logic              ctr_clear;
    logic              ctr_inc;
    logic              scan_rd;
    logic              free_rd;
    logic              sweep_wr;
    logic              sweep_rst;
    logic              alloc_wr;
    logic              free_wr;
    logic              pend_load;
    logic [CODE_W-1:0] pend_code;
    logic              pend_hit;
    logic              out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic ctr_last;
    logic rd_valid;
    logic rd_last;
    logic hit;
    logic free_bad;
  } dp_sts_t;

endpackage

[src/bsa_dpath.sv]
module bsa_dpath
  import bsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_ctl_t           ctl,
  output dp_sts_t           sts,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic [OFF_W-1:0]  free_offset,
  output logic [CODE_W-1:0] result_code,
  output logic [OFF_W-1:0]  block_offset
);

  logic [WORD_W-1:0]  mem [WORDS];

  logic [CNT_W-1:0]   reserved_count;
  logic [WADDR_W-1:0] ctr;
  logic [OFF_W-1:0]   off_q;
  logic               rd_valid;
  logic [WORD_W-1:0]  rd_data;
  logic [WADDR_W-1:0] rd_addr_q;
  logic [CODE_W-1:0]  pend_code;
  logic [OFF_W-1:0]   pend_offset;

  logic [IDX_W-1:0]   free_idx;
  logic [WADDR_W-1:0] rd_addr;
  logic               rd_en;
  logic               hit;
  logic [LANE_W-1:0]  hit_lane;
  logic [OFF_W-1:0]   hit_offset;
  logic [CNT_W-1:0]   sweep_count;
  logic [WORD_W-1:0]  sweep_word;
  logic [LANE_W-1:0]  mod_lane;
  logic [ST_W-1:0]    mod_val;
  logic [WORD_W-1:0]  mod_word;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_count <= RESERVED_RESET;
      ctr            <= '0;
      rd_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        reserved_count <= cfg_data;
      end
      if (ctl.ctr_clear) begin
        ctr <= '0;
      end else if (ctl.ctr_inc) begin
        ctr <= ctr + WADDR_W'(1);
      end
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      off_q <= free_offset;
    end
    if (ctl.pend_load) begin
      pend_code   <= ctl.pend_code;
      pend_offset <= ctl.pend_hit ? hit_offset : '0;
    end
    if (ctl.out_load) begin
      result_code  <= pend_code;
      block_offset <= pend_offset;
    end
  end

  assign free_idx = IDX_W'(off_q >> BLOCK_SIZE_LOG2);
  assign rd_en    = ctl.scan_rd | ctl.free_rd;
  assign rd_addr  = ctl.free_rd ? free_idx[IDX_W-1:LANE_W] : ctr;

  // First unused lane of the returned word; the lowest lane wins.
  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (rd_data[j*ST_W +: ST_W] == ST_UNUSED) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(j);
      end
    end
  end

  assign hit_offset = OFF_W'({rd_addr_q, hit_lane}) << BLOCK_SIZE_LOG2;

  assign sweep_count = ctl.sweep_rst ? RESERVED_RESET : reserved_count;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      sweep_word[j*ST_W +: ST_W] =
        ((32'({ctr, LANE_W'(0)}) + 32'(j)) < 32'(sweep_count)) ? ST_RESERVED : ST_UNUSED;
    end
  end

  assign mod_lane = ctl.alloc_wr ? hit_lane : free_idx[LANE_W-1:0];
  assign mod_val  = ctl.alloc_wr ? ST_IN_USE : ST_UNUSED;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      mod_word[j*ST_W +: ST_W] =
        (LANE_W'(j) == mod_lane) ? mod_val : rd_data[j*ST_W +: ST_W];
    end
  end

  assign wr_en   = ctl.sweep_wr | ctl.alloc_wr | ctl.free_wr;
  assign wr_addr = ctl.sweep_wr ? ctr : rd_addr_q;
  assign wr_data = ctl.sweep_wr ? sweep_word : mod_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign sts.ctr_last = (ctr == WADDR_W'(WORDS - 1));
  assign sts.rd_valid = rd_valid;
  assign sts.rd_last  = (rd_addr_q == WADDR_W'(WORDS - 1));
  assign sts.hit      = hit;
  assign sts.free_bad = (32'(off_q >> BLOCK_SIZE_LOG2) >= 32'(NUM_BLOCKS));

endmodule

[src/bsa_ctrl.sv]
`include "block_status_bitmap_allocator_core_macros.svh"

module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_ctl_t          ctl,
  input  dp_sts_t          sts
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.ctr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ALLOC: state_next = S_ALLOC;
            CMD_FREE:  state_next = S_FREE_RD;
            CMD_INIT:  state_next = S_INIT;
            default:   state_next = S_RESULT;
          endcase
        end
      end
      S_ALLOC: begin
        if (sts.rd_valid && (sts.hit || sts.rd_last)) state_next = S_RESULT;
      end
      S_FREE_RD: begin
        state_next = sts.free_bad ? S_RESULT : S_FREE_WR;
      end
      S_FREE_WR: state_next = S_RESULT;
      S_INIT: begin
        if (sts.ctr_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.sweep_wr  = 1'b1;
        ctl.sweep_rst = 1'b1;
        ctl.ctr_inc   = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          ctl.in_load   = 1'b1;
          ctl.ctr_clear = 1'b1;
          // unknown command: answer ok at once
          if (!(cmd inside {CMD_ALLOC, CMD_FREE, CMD_INIT})) begin
            ctl.pend_load = 1'b1;
            ctl.pend_code = RC_OK;
          end
        end
      end
      S_ALLOC: begin
        // stream one word a cycle; check the word read last cycle
        ctl.scan_rd = 1'b1;
        ctl.ctr_inc = 1'b1;
        if (sts.rd_valid && sts.hit) begin
          ctl.alloc_wr  = 1'b1;
          ctl.pend_load = 1'b1;
          ctl.pend_code = RC_OK;
          ctl.pend_hit  = 1'b1;
        end else if (sts.rd_valid && sts.rd_last) begin
          ctl.pend_load = 1'b1;
          ctl.pend_code = RC_NO_SPACE;
        end
      end
      S_FREE_RD: begin
        if (sts.free_bad) begin
          ctl.pend_load = 1'b1;
          ctl.pend_code = RC_RANGE;
        end else begin
          ctl.free_rd = 1'b1;
        end
      end
      S_FREE_WR: begin
        ctl.free_wr   = 1'b1;
        ctl.pend_load = 1'b1;
        ctl.pend_code = RC_OK;
      end
      S_INIT: begin
        ctl.sweep_wr = 1'b1;
        ctl.ctr_inc  = 1'b1;
        if (sts.ctr_last) begin
          ctl.pend_load = 1'b1;
          ctl.pend_code = RC_OK;
        end
      end
      S_RESULT: begin
        ctl.out_load = slot_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `BSA_ASSERT_NEXT(a_accept_leaves_idle, accept, state != S_IDLE)
  `BSA_ASSERT_NEXT(a_result_loads_out, state == S_RESULT && slot_free, out_valid)
  `BSA_ASSERT_NOW(a_single_writer, ctl.alloc_wr, !ctl.sweep_wr && !ctl.free_wr)
  `BSA_ASSERT_NOW(a_alloc_needs_data, ctl.alloc_wr, sts.rd_valid && sts.hit)

endmodule

[src/block_status_bitmap_allocator_core.sv]
// Block status allocator: one 2-bit status (unused, reserved, in use) per storage block.
// Request channel in_valid/in_ready carries cmd (allocate, free, init) and free_offset.
// Result channel out_valid/out_ready returns result_code and block_offset, one per request.
// Config channel cfg_valid/cfg_ready writes reserved_count; it is always ready and
// should be written only while no request is in flight.
// The map lives in a 256 x 32-bit memory, 16 statuses per word, one port read per cycle.
// Allocate streams one word per cycle and stops at the first word with an unused block;
// free reads the word, then writes it back. Init writes one word per cycle.
// Requests are handled one at a time.
// At reset a sweep of the map marks the lowest 8 blocks reserved and the rest unused;
// in_ready stays low until it ends.
// A finished result sits in an output register; the next request is accepted while it
// waits, and a later result holds in the pending register until the receiver takes the first.
module block_status_bitmap_allocator_core
  import bsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [OFF_W-1:0]  free_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] result_code,
  output logic [OFF_W-1:0]  block_offset,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  bsa_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .free_offset  (free_offset),
    .result_code  (result_code),
    .block_offset (block_offset)
  );

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int SEG_ITEMS   = 55;
  localparam int MAX_REPORTS = 10;
  localparam int IN_BLOCK    = (1 << BLOCK_SIZE_LOG2) - 1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [OFF_W-1:0]  offset;
  } alloc_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CNT_W-1:0]  cfg_val;
    logic [CMD_W-1:0]  op;
    logic [OFF_W-1:0]  offset;
    bit                typed;
    logic [CODE_W-1:0] t_code;
    logic [OFF_W-1:0]  t_off;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd = '0;
  logic [OFF_W-1:0]  free_offset = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] result_code;
  logic [OFF_W-1:0]  block_offset;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  // block status model
  logic [ST_W-1:0]  model_map [NUM_BLOCKS];
  logic [CNT_W-1:0] model_reserved;
  int               last_alloc_idx = 0;

  alloc_result_t owed_results [$];
  dir_row_t      dir_tab [$];

  int err_count     = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_reqs    = 0;
  int stall_seen    = 0;
  int hold_left     = 0;

  block_status_bitmap_allocator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .free_offset  (free_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_code  (result_code),
    .block_offset (block_offset),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void sweep_model_map();
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      model_map[k] = (k < int'(model_reserved)) ? ST_RESERVED : ST_UNUSED;
    end
  endfunction

  function automatic void apply_request(input logic [CMD_W-1:0] op,
                                        input logic [OFF_W-1:0] offset,
                                        output alloc_result_t res);
    int idx;
    bit found;
    res.code   = RC_OK;
    res.offset = '0;
    found      = 1'b0;
    case (op)
      CMD_ALLOC: begin
        for (int k = 0; k < NUM_BLOCKS && !found; k++) begin
          if (model_map[k] == ST_UNUSED) begin
            model_map[k]   = ST_IN_USE;
            res.offset     = OFF_W'(k << BLOCK_SIZE_LOG2);
            last_alloc_idx = k;
            found          = 1'b1;
          end
        end
        if (!found) res.code = RC_NO_SPACE;
      end
      CMD_FREE: begin
        idx = int'(offset >> BLOCK_SIZE_LOG2);
        if (idx < NUM_BLOCKS) model_map[idx] = ST_UNUSED;
        else res.code = RC_RANGE;
      end
      CMD_INIT: sweep_model_map();
      default: ;
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] blk_off(input int idx);
    return OFF_W'(idx << BLOCK_SIZE_LOG2);
  endfunction

  function automatic dir_row_t req_row(input logic [CMD_W-1:0] op,
                                       input logic [OFF_W-1:0] offset,
                                       input bit typed,
                                       input logic [CODE_W-1:0] t_code,
                                       input logic [OFF_W-1:0] t_off);
    dir_row_t r;
    r.kind    = ROW_REQ;
    r.cfg_val = '0;
    r.op      = op;
    r.offset  = offset;
    r.typed   = typed;
    r.t_code  = t_code;
    r.t_off   = t_off;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CNT_W-1:0] v);
    dir_row_t r;
    r         = req_row(CMD_NONE, '0, 1'b0, RC_OK, '0);
    r.kind    = ROW_CFG;
    r.cfg_val = v;
    return r;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] op,
                              input logic [OFF_W-1:0] offset,
                              input bit typed,
                              input logic [CODE_W-1:0] t_code,
                              input logic [OFF_W-1:0] t_off);
    alloc_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    free_offset <= offset;
    do @(posedge clk); while (!in_ready);
    apply_request(op, offset, res);
    if (typed) begin
      res.code   = t_code;
      res.offset = t_off;
    end
    owed_results.push_back(res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reserved(input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model_reserved = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] rsv;
    logic [CMD_W-1:0] op;
    logic [OFF_W-1:0] offset;
    int roll;
    int lo;

    model_reserved = RESERVED_RESET;
    sweep_model_map();

    // defaults after reset: blocks 0..7 reserved
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_OK, blk_off(8)));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_OK, blk_off(9)));
    dir_tab.push_back(req_row(CMD_FREE, blk_off(8) | OFF_W'(IN_BLOCK), 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b0, RC_OK, '0));
    // free a reserved block that was never in use
    dir_tab.push_back(req_row(CMD_FREE, '0, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b0, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_FREE, '1, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_NONE, '1, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_INIT, '0, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_OK, blk_off(8)));
    // count above the map size: everything reserved
    dir_tab.push_back(cfg_row('1));
    dir_tab.push_back(req_row(CMD_INIT, '0, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_NO_SPACE, '0));
    dir_tab.push_back(req_row(CMD_FREE, blk_off(4095) | OFF_W'(5), 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_OK, blk_off(4095)));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_NO_SPACE, '0));
    dir_tab.push_back(cfg_row(CNT_W'(NUM_BLOCKS)));
    dir_tab.push_back(req_row(CMD_INIT, '0, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_NO_SPACE, '0));
    dir_tab.push_back(cfg_row('0));
    dir_tab.push_back(req_row(CMD_INIT, '0, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_OK, blk_off(0)));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b0, RC_OK, '0));
    dir_tab.push_back(cfg_row(CNT_W'(NUM_BLOCKS - 1)));
    dir_tab.push_back(req_row(CMD_INIT, '0, 1'b1, RC_OK, '0));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_OK, blk_off(NUM_BLOCKS - 1)));
    dir_tab.push_back(req_row(CMD_ALLOC, '0, 1'b1, RC_NO_SPACE, '0));

    send_idle_pct = 36;
    recv_idle_pct = 66;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_results();
        write_reserved(dir_tab[i].cfg_val);
      end else begin
        send_request(dir_tab[i].op, dir_tab[i].offset, dir_tab[i].typed,
                     dir_tab[i].t_code, dir_tab[i].t_off);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 36 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        drain_results();
        case (seg)
          0: rsv = CNT_W'($urandom_range(64));
          1: rsv = CNT_W'(NUM_BLOCKS - $urandom_range(12));
          2: rsv = CNT_W'($urandom_range((1 << CNT_W) - 1, NUM_BLOCKS + 1));
          3: rsv = '0;
          4: rsv = CNT_W'($urandom());
          default: rsv = CNT_W'($urandom_range(2048));
        endcase
        write_reserved(rsv);
        // starve the output for a while so the block backs up into its input
        if (seg == 2) stall_reqs <= stall_reqs + 1;
        send_request(CMD_INIT, OFF_W'($urandom()), 1'b0, RC_OK, '0);
        for (int n = 0; n < SEG_ITEMS; n++) begin
          roll   = $urandom_range(99);
          offset = OFF_W'($urandom());
          if (roll < 45) begin
            op = CMD_ALLOC;
          end else if (roll < 85) begin
            op = CMD_FREE;
            // aim at recently allocated blocks to open holes below the scan point
            if (roll < 65) begin
              lo     = (last_alloc_idx > 8) ? last_alloc_idx - 8 : 0;
              offset = blk_off($urandom_range(last_alloc_idx, lo)) |
                       OFF_W'($urandom_range(IN_BLOCK));
            end
          end else if (roll < 93) begin
            op = CMD_INIT;
          end else begin
            op = CMD_NONE;
          end
          send_request(op, offset, 1'b0, RC_OK, '0);
        end
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (err_count == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: code %0d offset 0x%0h", result_code, block_offset);
        end else begin
          want = owed_results.pop_front();
          if (result_code !== want.code || block_offset !== want.offset) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch: code exp %0d got %0d, offset exp 0x%0h got 0x%0h",
                       want.code, result_code, want.offset, block_offset);
          end
        end
      end
      if (stall_reqs != stall_seen) begin
        stall_seen <= stall_reqs;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[filelist.f]
+incdir+src
src/bsa_pkg.sv
src/bsa_dpath.sv
src/bsa_ctrl.sv
src/block_status_bitmap_allocator_core.sv
test/tb_top.sv
